FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// A condition that forces a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and the CRC-16 byte fold shared by the packet framer.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int PFC_BUF_DEPTH = 6;
    localparam int PFC_CNT_W     = 3;
    localparam int PFC_IDX_W     = 3;

    localparam logic [15:0] PFC_CRC_INIT = 16'hFFFF;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_DATA  = 1'b1
    } pfc_func_t;

    typedef struct packed {
        pfc_func_t   func;
        logic [7:0]  frame_type;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
    } pfc_item_t;

    // Words produced by one item, entry 0 goes out first.
    typedef struct packed {
        logic [PFC_BUF_DEPTH-1:0][7:0] bytes;
        logic [PFC_CNT_W-1:0]          cnt;
        logic                          tail;
    } pfc_load_t;

    // One byte of CRC-16 with polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] x;
        x = crc[15:8] ^ data;
        x = x ^ (x >> 4);
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
               ^ {8'h00, x};
    endfunction

endpackage

FILE: hdl/pfc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_engine
// Frame state and CRC; turns one item into the words it produces.
// ----------------------------------------------------------------------------
module pfc_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  pfc_pkg::pfc_item_t item,
    input  logic [7:0]         sync_value,
    output pfc_pkg::pfc_load_t load
);
    import pfc_pkg::*;

    logic [15:0] crc_reg,  crc_next;
    logic [15:0] left_reg, left_next;
    logic        open_reg, open_next;

    logic [15:0] c1, c2, c3, c4, cp;
    logic        len_zero;
    logic        last_data;

    // Header CRC is four chained byte folds from the initial value.
    assign c1        = crc_fold(PFC_CRC_INIT, sync_value);
    assign c2        = crc_fold(c1, item.frame_type);
    assign c3        = crc_fold(c2, item.payload_length[7:0]);
    assign c4        = crc_fold(c3, item.payload_length[15:8]);
    assign cp        = crc_fold(crc_reg, item.payload_byte);
    assign len_zero  = (item.payload_length == 16'd0);
    assign last_data = (left_reg == 16'd1);

    always_comb
    begin
        load      = '0;
        crc_next  = crc_reg;
        left_next = left_reg;
        open_next = open_reg;
        unique case (item.func)
            FUNC_START:
            begin
                load.bytes[0] = sync_value;
                load.bytes[1] = item.frame_type;
                load.bytes[2] = item.payload_length[7:0];
                load.bytes[3] = item.payload_length[15:8];
                load.bytes[4] = c4[7:0];
                load.bytes[5] = c4[15:8];
                load.cnt      = len_zero ? PFC_CNT_W'(6) : PFC_CNT_W'(4);
                load.tail     = len_zero;
                crc_next      = len_zero ? PFC_CRC_INIT : c4;
                left_next     = item.payload_length;
                open_next     = !len_zero;
            end
            FUNC_DATA:
            begin
                // A data word with no open frame is dropped.
                if (open_reg && (left_reg != 16'd0))
                begin
                    load.bytes[0] = item.payload_byte;
                    load.bytes[1] = cp[7:0];
                    load.bytes[2] = cp[15:8];
                    load.cnt      = last_data ? PFC_CNT_W'(3) : PFC_CNT_W'(1);
                    load.tail     = last_data;
                    crc_next      = last_data ? PFC_CRC_INIT : cp;
                    left_next     = left_reg - 16'd1;
                    open_next     = !last_data;
                end
            end
            default:
            begin
                load = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= PFC_CRC_INIT;
            left_reg <= 16'd0;
            open_reg <= 1'b0;
        end
        else if (take)
        begin
            crc_reg  <= crc_next;
            left_reg <= left_next;
            open_reg <= open_next;
        end
    end

endmodule

FILE: hdl/packet_framer_crc16.sv
`timescale 1ns / 1ps
// A word accepted at the input is registered in s1_item_reg, then loaded into the
// output buffer once it is free. One payload word per cycle while out_ready is high;
// a start word loads four output words (six with zero length) and the closing word
// three, and the input waits while they drain. Reset clears the frame state, CRC and sync byte.
// ----------------------------------------------------------------------------
// packet_framer_crc16
// Serializes framed packets with a CRC-16 trailer, one byte per output word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packet_framer_crc16
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  frame_type,
    input  logic [15:0] payload_length,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        frame_end
);
    import pfc_pkg::*;

    logic [7:0]                    sync_reg;
    logic                          s1_valid_reg;
    pfc_item_t                     s1_item_reg;
    logic [PFC_BUF_DEPTH-1:0][7:0] buf_reg;
    logic [PFC_CNT_W-1:0]          cnt_reg;
    logic [PFC_IDX_W-1:0]          idx_reg;
    logic                          tail_reg;

    pfc_load_t load;
    logic      s1_take;
    logic      buf_free;
    logic      last;
    logic      out_take;

    assign last      = (idx_reg == (cnt_reg - PFC_CNT_W'(1)));
    assign out_valid = (cnt_reg != '0);
    assign out_take  = out_valid && out_ready;
    assign buf_free  = !out_valid || (out_take && last);
    assign s1_take   = s1_valid_reg && buf_free;
    assign in_ready  = !s1_valid_reg || buf_free;
    assign out_byte  = buf_reg[idx_reg];
    assign frame_end = out_valid && last && tail_reg;

    pfc_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (s1_take),
        .item       (s1_item_reg),
        .sync_value (sync_reg),
        .load       (load)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            sync_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.func           <= pfc_func_t'(func);
            s1_item_reg.frame_type     <= frame_type;
            s1_item_reg.payload_length <= payload_length;
            s1_item_reg.payload_byte   <= payload_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            idx_reg  <= '0;
            tail_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            cnt_reg  <= load.cnt;
            idx_reg  <= '0;
            tail_reg <= load.tail;
        end
        else if (out_take)
        begin
            if (last)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + PFC_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            buf_reg <= load.bytes;
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_reg <= PFC_CNT_W'(PFC_BUF_DEPTH))
    `ASSERT_ALWAYS(a_idx_in_buf, clk, rst_n, !out_valid || (idx_reg < cnt_reg))
    `ASSERT_NEXT(a_drain_empty, clk, rst_n, out_take && last && !s1_take, !out_valid)
    `ASSERT_ALWAYS(a_end_has_crc, clk, rst_n, !frame_end || (cnt_reg == PFC_CNT_W'(3))
                   || (cnt_reg == PFC_CNT_W'(6)))

endmodule

FILE: bench/pfc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_frame_checker
// Watches the framer's ports, rebuilds every packet byte and its CRC-16, and
// compares each output word in order with the bytes it predicted.
// ----------------------------------------------------------------------------
module pfc_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic [7:0]  frame_type,
    input  logic [15:0] payload_length,
    input  logic [7:0]  payload_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        frame_end,
    output int          fails,
    output int          pending
);
    import pfc_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    stream_byte_t expected_bytes[$];

    logic [7:0]  sync_byte;
    logic [15:0] crc_acc;
    logic [15:0] bytes_owed;
    logic        open_frame;

    // Bit-serial CRC-16, polynomial 0x1021, most significant bit first.
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        int          i;
        c = crc ^ {data, 8'h00};
        for (i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    task automatic emit_data(input logic [7:0] b);
        crc_acc = crc16_next(crc_acc, b);
        expected_bytes.push_back('{value: b, last: 1'b0});
    endtask

    task automatic emit_crc();
        expected_bytes.push_back('{value: crc_acc[7:0], last: 1'b0});
        expected_bytes.push_back('{value: crc_acc[15:8], last: 1'b1});
        crc_acc    = PFC_CRC_INIT;
        bytes_owed = '0;
        open_frame = 1'b0;
    endtask

    task automatic predict_frame_bytes(input pfc_func_t f, input logic [7:0] t,
                                       input logic [15:0] len, input logic [7:0] pb);
        if (f == FUNC_START)
        begin
            // A start word always restarts the packet, even over an open one.
            crc_acc = PFC_CRC_INIT;
            emit_data(sync_byte);
            emit_data(t);
            emit_data(len[7:0]);
            emit_data(len[15:8]);
            if (len == 16'd0)
            begin
                emit_crc();
            end
            else
            begin
                bytes_owed = len;
                open_frame = 1'b1;
            end
        end
        else if (open_frame && bytes_owed != 16'd0)
        begin
            emit_data(pb);
            bytes_owed = bytes_owed - 16'd1;
            if (bytes_owed == 16'd0)
            begin
                emit_crc();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stream_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            sync_byte  = 8'h00;
            crc_acc    = PFC_CRC_INIT;
            bytes_owed = '0;
            open_frame = 1'b0;
            fails      = 0;
            pending    = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_frame_bytes(pfc_func_t'(func), frame_type, payload_length,
                                    payload_byte);
            end
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual byte %h end %b",
                             $time, out_byte, frame_end);
                    fails++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (want.value !== out_byte)
                    begin
                        $display("%0t: out_byte expected %h, actual %h",
                                 $time, want.value, out_byte);
                        fails++;
                    end
                    if (want.last !== frame_end)
                    begin
                        $display("%0t: frame_end expected %b, actual %b",
                                 $time, want.last, frame_end);
                        fails++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                sync_byte = cfg_wr_data;
            end
            pending = expected_bytes.size();
        end
    end

endmodule

FILE: bench/tb_packet_framer_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_framer_crc16
// Drives start and payload words into the packet framer, with directed edge
// cases first and then random frames under several sync bytes, while the
// output side stalls at random; the checker judges every output word.
// ----------------------------------------------------------------------------
module tb_packet_framer_crc16;

    import pfc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_ITEMS   = 60;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        frame_end;

    int   fails;
    int   pending;
    int   cycle_count = 0;
    int   rx_cycle;
    int   hold_left;
    logic steady_in;
    logic hold_req;
    logic hold_done;

    packet_framer_crc16 i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .frame_type     (frame_type),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .frame_end      (frame_end)
    );

    pfc_frame_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .frame_type     (frame_type),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .frame_end      (frame_end),
        .fails          (fails),
        .pending        (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("packet_framer_crc16: mismatch");
            $finish;
        end
    end

    // Output side: random stalls, one steady stretch, and one long hold-off
    // that lets the framer fill up and push back on its input.
    initial
    begin
        out_ready = 1'b0;
        rx_cycle  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (rx_cycle >= 900 && rx_cycle < 1500)
            begin
                out_ready = 1'b1;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= 27);
            end
        end
    end

    task automatic send_word(input pfc_func_t f, input logic [7:0] t,
                             input logic [15:0] len, input logic [7:0] pb);
        @(negedge clk);
        // Each cycle the sender idles with the same odds, so gaps stay short.
        if (!steady_in)
        begin
            while ($urandom_range(99) < 27)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid       = 1'b1;
        func           = f;
        frame_type     = t;
        payload_length = len;
        payload_byte   = pb;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_start(input logic [7:0] t, input logic [15:0] len);
        send_word(FUNC_START, t, len, 8'($urandom_range(255)));
    endtask

    task automatic send_payload(input logic [7:0] pb);
        send_word(FUNC_DATA, 8'($urandom_range(255)), 16'($urandom_range(65535)), pb);
    endtask

    // Waits until every predicted word has come out, plus a margin for a
    // dropped payload word that may still be in flight.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // Mostly complete frames with random content; some stray payload words,
    // some frames cut short by the next start, and a few huge lengths.
    task automatic random_phase(input int n_items);
        int          sent;
        int          pick;
        int          n_data;
        int          i;
        logic [15:0] len;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_payload(8'($urandom_range(255)));
            end
            else
            begin
                if (pick < 18)
                    len = 16'd0;
                else if (pick < 80)
                    len = 16'($urandom_range(8, 1));
                else if (pick < 93)
                    len = 16'($urandom_range(40, 9));
                else
                    len = 16'($urandom_range(16'hFFFF, 16'h0100));
                n_data = len;
                if (len > 16'd40)
                    n_data = $urandom_range(5, 0);
                else if (len != 16'd0 && $urandom_range(99) < 8)
                    n_data = $urandom_range(len - 1, 0);
                send_start(8'($urandom_range(255)), len);
                for (i = 0; i < n_data; i++)
                begin
                    send_payload(8'($urandom_range(255)));
                end
                sent += 1 + n_data;
            end
        end
    endtask

    initial
    begin
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 8'h00;
        in_valid       = 1'b0;
        func           = FUNC_START;
        frame_type     = 8'h00;
        payload_length = 16'h0000;
        payload_byte   = 8'h00;
        steady_in      = 1'b0;
        hold_req       = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sync byte still at its reset value; a payload word with no frame is dropped.
        send_payload(8'hAA);
        send_start(8'h00, 16'h0000);
        settle();
        write_sync(8'hFF);

        send_start(8'hFF, 16'h0000);
        send_start(8'h5A, 16'd3);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h80);
        send_payload(8'h55);
        // Long frames that get abandoned by the next start.
        send_start(8'h01, 16'hFFFF);
        send_payload(8'h12);
        send_payload(8'h34);
        send_start(8'h80, 16'h8000);
        send_payload(8'hFE);
        send_start(8'h7F, 16'h0100);
        send_start(8'hC3, 16'd1);
        send_payload(8'h7F);
        send_start(8'h3C, 16'd2);
        send_payload(8'h01);
        send_start(8'hA5, 16'h00FF);
        send_start(8'h11, 16'd1);
        send_payload(8'hAB);
        settle();

        write_sync(8'($urandom_range(254, 1)));
        hold_req = 1'b1;
        random_phase(PHASE_ITEMS);
        settle();

        write_sync(8'h00);
        steady_in = 1'b1;
        random_phase(PHASE_ITEMS);
        steady_in = 1'b0;
        settle();

        write_sync(8'h80);
        random_phase(PHASE_ITEMS);
        settle();

        write_sync(8'($urandom_range(255)));
        random_phase(PHASE_ITEMS);
        settle();

        if (fails == 0)
        begin
            $display("packet_framer_crc16: match");
        end
        else
        begin
            $display("packet_framer_crc16: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pfc_engine.sv
hdl/packet_framer_crc16.sv
bench/pfc_frame_checker.sv
bench/tb_packet_framer_crc16.sv
